// ===== hdl/tspp_pkg.sv =====
// Shared constants, record kind codes and the record type of the TS PAT/PMT parser.
`timescale 1ns / 1ps

package tspp_pkg;

    // Packet length in bytes; the position counter is 8 bits wide.
    localparam int unsigned PACKET_BYTES = 188;
    localparam int unsigned POS_W        = 8;

    localparam logic [7:0] SYNC_MARK = 8'h47;
    localparam logic [7:0] TID_PAT   = 8'h00;
    localparam logic [7:0] TID_PMT   = 8'h02;

    // Byte positions inside a packet.
    localparam logic [POS_W-1:0] POS_SYNC       = 8'd0;
    localparam logic [POS_W-1:0] POS_HDR_LAST   = 8'd3;
    localparam logic [POS_W-1:0] POS_TID        = 8'd5;
    localparam logic [POS_W-1:0] POS_SEC_LEN_HI = 8'd6;
    localparam logic [POS_W-1:0] POS_SEC_LEN_LO = 8'd7;
    localparam logic [POS_W-1:0] POS_PROG_HI    = 8'd8;
    localparam logic [POS_W-1:0] POS_PROG_LO    = 8'd9;
    localparam logic [POS_W-1:0] POS_BODY       = 8'd13;
    localparam logic [POS_W-1:0] POS_PMT_HEAD   = 8'd16;

    localparam logic [1:0] KIND_HEADER    = 2'd0;
    localparam logic [1:0] KIND_PAT_ENTRY = 2'd1;
    localparam logic [1:0] KIND_PMT_HEAD  = 2'd2;
    localparam logic [1:0] KIND_PMT_ENTRY = 2'd3;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [12:0] pid_value;
        logic        error_flag;
        logic        unit_start_flag;
        logic        priority_flag;
        logic [1:0]  scrambling_bits;
        logic [1:0]  adaptation_bits;
        logic [3:0]  continuity_count;
        logic [15:0] program_id;
        logic [7:0]  stream_kind;
        logic [11:0] info_length;
    } record_t;

endpackage

// ===== hdl/ts_packet_pat_pmt_parser_core.sv =====
// Top level of the TS PAT/PMT parser: input stage, parser and result register.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------------
//  s_       | in        | s_valid / s_ready  | s_byte_value (one stream byte)
//  m_       | out       | m_valid / m_ready  | m_record_kind .. m_info_length (record)
//
// One byte is taken per cycle while the result is not stalled; each byte passes
// the input register, then the parser logic into the result register, from
// which its record is presented. At most one record follows from each byte.
// Synchronous active-low reset puts the parser at the start of a packet.
// A stalled result holds the parser and the input register; the input side keeps
// taking a byte while the input register is empty.
`timescale 1ns / 1ps

module ts_packet_pat_pmt_parser_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_record_kind,
    output logic [12:0] m_pid_value,
    output logic        m_error_flag,
    output logic        m_unit_start_flag,
    output logic        m_priority_flag,
    output logic [1:0]  m_scrambling_bits,
    output logic [1:0]  m_adaptation_bits,
    output logic [3:0]  m_continuity_count,
    output logic [15:0] m_program_id,
    output logic [7:0]  m_stream_kind,
    output logic [11:0] m_info_length
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               advance;
    logic               rec_valid;
    tspp_pkg::record_t  rec;
    logic               out_valid_reg;
    tspp_pkg::record_t  out_reg;

    // The buffered byte moves on whenever the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
        end
    end

    tspp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .byte_value (in_byte_reg),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= rec_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_valid) begin
            out_reg <= rec;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_record_kind      = out_reg.record_kind;
    assign m_pid_value        = out_reg.pid_value;
    assign m_error_flag       = out_reg.error_flag;
    assign m_unit_start_flag  = out_reg.unit_start_flag;
    assign m_priority_flag    = out_reg.priority_flag;
    assign m_scrambling_bits  = out_reg.scrambling_bits;
    assign m_adaptation_bits  = out_reg.adaptation_bits;
    assign m_continuity_count = out_reg.continuity_count;
    assign m_program_id       = out_reg.program_id;
    assign m_stream_kind      = out_reg.stream_kind;
    assign m_info_length      = out_reg.info_length;

    // A byte waiting in the input register is neither lost nor changed under a stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input byte lost or changed while stalled");

    // Header fields are zero on every record that is not a packet header.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_kind != tspp_pkg::KIND_HEADER) |->
        (!m_error_flag && !m_unit_start_flag && !m_priority_flag &&
         m_scrambling_bits == 2'd0 && m_adaptation_bits == 2'd0 &&
         m_continuity_count == 4'd0))
        else $error("header field set on a table record");

    // Only stream entries carry a stream type, and PAT entries carry no info length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_record_kind != tspp_pkg::KIND_PMT_ENTRY) |->
        (m_stream_kind == 8'd0 &&
         (m_record_kind != tspp_pkg::KIND_PAT_ENTRY || m_info_length == 12'd0)))
        else $error("stray stream type or info length on a record");

endmodule

// ===== hdl/tspp_parser.sv =====
// Per-byte packet tracking and PAT/PMT section parsing state.
`timescale 1ns / 1ps

module tspp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic [7:0]            byte_value,
    output logic                  rec_valid,
    output tspp_pkg::record_t     rec
);

    typedef enum logic [1:0] {
        MODE_NONE       = 2'd0,
        MODE_PAT        = 2'd1,
        MODE_PMT_HEAD   = 2'd2,
        MODE_PMT_STREAM = 2'd3
    } mode_t;

    logic [tspp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       drop_reg, drop_next;
    logic [23:0]                hdr_reg, hdr_next;
    mode_t                      mode_reg, mode_next;
    logic [11:0]                send_reg, send_next;
    logic [2:0]                 idx_reg, idx_next;
    logic [39:0]                ea_reg, ea_next;
    logic [11:0]                skip_reg, skip_next;

    logic [tspp_pkg::POS_W:0]   pos_inc;
    logic [12:0]                len_sum;
    logic [39:0]                ea_shift;
    logic [2:0]                 idx_inc;
    logic                       before_crc;
    logic                       produce;
    tspp_pkg::record_t          rec_c;

    always_comb begin
        pos_inc    = {1'b0, pos_reg} + 9'd1;
        len_sum    = {1'b0, ea_reg[3:0], byte_value} + 13'd4;
        ea_shift   = {ea_reg[31:0], byte_value};
        idx_inc    = idx_reg + 3'd1;
        before_crc = ({4'b0, pos_reg} < send_reg);

        pos_next  = (pos_inc >= 9'(tspp_pkg::PACKET_BYTES)) ? '0 : pos_inc[7:0];
        drop_next = drop_reg;
        hdr_next  = hdr_reg;
        mode_next = mode_reg;
        send_next = send_reg;
        idx_next  = idx_reg;
        ea_next   = ea_reg;
        skip_next = skip_reg;
        produce   = 1'b0;
        rec_c     = '0;

        if (pos_reg == tspp_pkg::POS_SYNC) begin
            drop_next = (byte_value != tspp_pkg::SYNC_MARK);
            hdr_next  = '0;
            mode_next = MODE_NONE;
            send_next = '0;
            idx_next  = '0;
            ea_next   = '0;
            skip_next = '0;
        end else if (drop_reg) begin
            // Lost sync: the rest of the packet is ignored.
        end else if (pos_reg <= tspp_pkg::POS_HDR_LAST) begin
            hdr_next = {hdr_reg[15:0], byte_value};
            if (pos_reg == tspp_pkg::POS_HDR_LAST) begin
                produce                = 1'b1;
                rec_c.record_kind      = tspp_pkg::KIND_HEADER;
                rec_c.pid_value        = hdr_reg[12:0];
                rec_c.error_flag       = hdr_reg[15];
                rec_c.unit_start_flag  = hdr_reg[14];
                rec_c.priority_flag    = hdr_reg[13];
                rec_c.scrambling_bits  = byte_value[7:6];
                rec_c.adaptation_bits  = byte_value[5:4];
                rec_c.continuity_count = byte_value[3:0];
            end
        end else if (pos_reg == tspp_pkg::POS_TID) begin
            if (hdr_reg[20:8] == 13'd0 && byte_value == tspp_pkg::TID_PAT) begin
                mode_next = MODE_PAT;
            end else if (byte_value == tspp_pkg::TID_PMT) begin
                mode_next = MODE_PMT_HEAD;
            end else begin
                mode_next = MODE_NONE;
            end
        end else if (pos_reg == tspp_pkg::POS_SEC_LEN_HI) begin
            ea_next = {32'b0, byte_value};
        end else if (pos_reg == tspp_pkg::POS_SEC_LEN_LO) begin
            // The section ends where its CRC begins; saturate at the field width.
            send_next = len_sum[12] ? 12'hFFF : len_sum[11:0];
            ea_next   = '0;
            idx_next  = '0;
        end else if (mode_reg == MODE_PMT_HEAD && pos_reg == tspp_pkg::POS_PROG_HI) begin
            hdr_next = {16'b0, byte_value};
        end else if (mode_reg == MODE_PMT_HEAD && pos_reg == tspp_pkg::POS_PROG_LO) begin
            hdr_next = {8'b0, hdr_reg[7:0], byte_value};
        end else if (pos_reg >= tspp_pkg::POS_BODY) begin
            case (mode_reg)
                MODE_PAT: begin
                    ea_next  = ea_shift;
                    idx_next = idx_inc;
                    if (idx_inc >= 3'd4) begin
                        idx_next = '0;
                        if (before_crc) begin
                            produce           = 1'b1;
                            rec_c.record_kind = tspp_pkg::KIND_PAT_ENTRY;
                            rec_c.pid_value   = ea_shift[12:0];
                            rec_c.program_id  = ea_shift[31:16];
                        end else begin
                            mode_next = MODE_NONE;
                        end
                    end
                end
                MODE_PMT_HEAD: begin
                    ea_next = ea_shift;
                    if (pos_reg == tspp_pkg::POS_PMT_HEAD) begin
                        produce           = 1'b1;
                        rec_c.record_kind = tspp_pkg::KIND_PMT_HEAD;
                        rec_c.pid_value   = ea_shift[28:16];
                        rec_c.program_id  = hdr_reg[15:0];
                        rec_c.info_length = ea_shift[11:0];
                        skip_next         = ea_shift[11:0];
                        idx_next          = '0;
                        ea_next           = '0;
                        mode_next         = MODE_PMT_STREAM;
                    end
                end
                MODE_PMT_STREAM: begin
                    if (skip_reg != 12'd0) begin
                        // Descriptor bytes are passed over by their length.
                        skip_next = skip_reg - 12'd1;
                    end else begin
                        ea_next  = ea_shift;
                        idx_next = idx_inc;
                        if (idx_inc >= 3'd5) begin
                            idx_next = '0;
                            if (before_crc) begin
                                produce           = 1'b1;
                                rec_c.record_kind = tspp_pkg::KIND_PMT_ENTRY;
                                rec_c.pid_value   = ea_shift[28:16];
                                rec_c.stream_kind = ea_shift[39:32];
                                rec_c.info_length = ea_shift[11:0];
                                skip_next         = ea_shift[11:0];
                            end else begin
                                mode_next = MODE_NONE;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            drop_reg <= 1'b0;
            hdr_reg  <= '0;
            mode_reg <= MODE_NONE;
            send_reg <= '0;
            idx_reg  <= '0;
            ea_reg   <= '0;
            skip_reg <= '0;
        end else if (step) begin
            pos_reg  <= pos_next;
            drop_reg <= drop_next;
            hdr_reg  <= hdr_next;
            mode_reg <= mode_next;
            send_reg <= send_next;
            idx_reg  <= idx_next;
            ea_reg   <= ea_next;
            skip_reg <= skip_next;
        end
    end

    assign rec_valid = step && produce;
    assign rec       = rec_c;

endmodule

// ===== tb/tb_ts_packet_pat_pmt_parser_core.sv =====
// Self-checking testbench for the TS PAT/PMT parser core with its own parser prediction.
`timescale 1ns / 1ps

module tb_ts_packet_pat_pmt_parser_core;

    localparam int STALL_LIMIT    = 2000;
    localparam int END_PAUSE      = 10;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int HOLDOFF_AT     = 300;
    localparam int CALM_FROM      = 500;
    localparam int CALM_TO        = 700;
    localparam int STREAM_BYTES   = 850;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_PAT,
        TBL_PMT_HEAD,
        TBL_PMT_STREAMS
    } tbl_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_byte_value = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_record_kind;
    logic [12:0] m_pid_value;
    logic        m_error_flag;
    logic        m_unit_start_flag;
    logic        m_priority_flag;
    logic [1:0]  m_scrambling_bits;
    logic [1:0]  m_adaptation_bits;
    logic [3:0]  m_continuity_count;
    logic [15:0] m_program_id;
    logic [7:0]  m_stream_kind;
    logic [11:0] m_info_length;

    ts_packet_pat_pmt_parser_core u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_byte_value       (s_byte_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_record_kind      (m_record_kind),
        .m_pid_value        (m_pid_value),
        .m_error_flag       (m_error_flag),
        .m_unit_start_flag  (m_unit_start_flag),
        .m_priority_flag    (m_priority_flag),
        .m_scrambling_bits  (m_scrambling_bits),
        .m_adaptation_bits  (m_adaptation_bits),
        .m_continuity_count (m_continuity_count),
        .m_program_id       (m_program_id),
        .m_stream_kind      (m_stream_kind),
        .m_info_length      (m_info_length)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Parser state as predicted from the accepted byte stream.
    logic [7:0]  pkt_pos     = '0;
    logic        pkt_dropped = 1'b0;
    logic [23:0] hdr_bytes   = '0;
    tbl_mode_t   tbl_mode    = TBL_NONE;
    logic [11:0] crc_pos     = '0;
    logic [2:0]  field_cnt   = '0;
    logic [39:0] field_acc   = '0;
    logic [11:0] desc_skip   = '0;

    tspp_pkg::record_t expected_records [$];
    logic [7:0]        pending_bytes [$];
    logic [7:0]        pkt_buf [tspp_pkg::PACKET_BYTES];

    int          bytes_total  = 0;
    int          bytes_taken  = 0;
    int          records_seen = 0;
    int          error_count  = 0;
    int          kind_seen [4];
    int          stall_cycles = 0;
    int          holdoff_left = 0;
    logic        holdoff_done = 1'b0;
    logic        byte_taken   = 1'b0;
    logic        calm_phase;
    tspp_pkg::record_t seen_rec;
    tspp_pkg::record_t want_rec;

    assign calm_phase = (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_TO);

    function automatic void parse_stream_byte(input logic [7:0] b);
        logic [7:0]        p;
        logic [12:0]       sec_sum;
        tspp_pkg::record_t rec;
        p = pkt_pos;
        pkt_pos = (p + 32'd1 >= tspp_pkg::PACKET_BYTES) ? 8'd0 : p + 8'd1;
        rec = '0;
        if (p == tspp_pkg::POS_SYNC) begin
            pkt_dropped = (b != tspp_pkg::SYNC_MARK);
            hdr_bytes = '0;
            tbl_mode = TBL_NONE;
            crc_pos = '0;
            field_cnt = '0;
            field_acc = '0;
            desc_skip = '0;
        end else if (!pkt_dropped) begin
            if (p <= tspp_pkg::POS_HDR_LAST) begin
                hdr_bytes = {hdr_bytes[15:0], b};
                if (p == tspp_pkg::POS_HDR_LAST) begin
                    rec.record_kind      = tspp_pkg::KIND_HEADER;
                    rec.pid_value        = hdr_bytes[20:8];
                    rec.error_flag       = hdr_bytes[23];
                    rec.unit_start_flag  = hdr_bytes[22];
                    rec.priority_flag    = hdr_bytes[21];
                    rec.scrambling_bits  = b[7:6];
                    rec.adaptation_bits  = b[5:4];
                    rec.continuity_count = b[3:0];
                    expected_records.push_back(rec);
                end
            end else if (p == tspp_pkg::POS_TID) begin
                if (hdr_bytes[20:8] == 13'd0 && b == tspp_pkg::TID_PAT) begin
                    tbl_mode = TBL_PAT;
                end else if (b == tspp_pkg::TID_PMT) begin
                    tbl_mode = TBL_PMT_HEAD;
                end else begin
                    tbl_mode = TBL_NONE;
                end
            end else if (p == tspp_pkg::POS_SEC_LEN_HI) begin
                field_acc = {32'd0, b};
            end else if (p == tspp_pkg::POS_SEC_LEN_LO) begin
                // The first CRC byte sits at the packet position of the section length plus four.
                sec_sum = {1'b0, field_acc[3:0], b} + 13'd4;
                crc_pos = (sec_sum > 13'hFFF) ? 12'hFFF : sec_sum[11:0];
                field_acc = '0;
                field_cnt = '0;
            end else if (tbl_mode == TBL_PMT_HEAD &&
                         (p == tspp_pkg::POS_PROG_HI || p == tspp_pkg::POS_PROG_LO)) begin
                hdr_bytes = (p == tspp_pkg::POS_PROG_HI) ? {16'd0, b}
                                                         : {8'd0, hdr_bytes[7:0], b};
            end else if (p >= tspp_pkg::POS_BODY) begin
                case (tbl_mode)
                    TBL_PAT: begin
                        field_acc = {field_acc[31:0], b};
                        field_cnt = field_cnt + 3'd1;
                        if (field_cnt >= 3'd4) begin
                            field_cnt = '0;
                            if (p < crc_pos) begin
                                rec.record_kind = tspp_pkg::KIND_PAT_ENTRY;
                                rec.pid_value   = field_acc[12:0];
                                rec.program_id  = field_acc[31:16];
                                expected_records.push_back(rec);
                            end else begin
                                tbl_mode = TBL_NONE;
                            end
                        end
                    end
                    TBL_PMT_HEAD: begin
                        field_acc = {field_acc[31:0], b};
                        if (p == tspp_pkg::POS_PMT_HEAD) begin
                            rec.record_kind = tspp_pkg::KIND_PMT_HEAD;
                            rec.pid_value   = field_acc[28:16];
                            rec.program_id  = hdr_bytes[15:0];
                            rec.info_length = field_acc[11:0];
                            expected_records.push_back(rec);
                            desc_skip = field_acc[11:0];
                            field_cnt = '0;
                            field_acc = '0;
                            tbl_mode = TBL_PMT_STREAMS;
                        end
                    end
                    TBL_PMT_STREAMS: begin
                        if (desc_skip != 12'd0) begin
                            desc_skip = desc_skip - 12'd1;
                        end else begin
                            field_acc = {field_acc[31:0], b};
                            field_cnt = field_cnt + 3'd1;
                            if (field_cnt >= 3'd5) begin
                                field_cnt = '0;
                                if (p < crc_pos) begin
                                    rec.record_kind = tspp_pkg::KIND_PMT_ENTRY;
                                    rec.pid_value   = field_acc[28:16];
                                    rec.stream_kind = field_acc[39:32];
                                    rec.info_length = field_acc[11:0];
                                    expected_records.push_back(rec);
                                    desc_skip = field_acc[11:0];
                                end else begin
                                    tbl_mode = TBL_NONE;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    endfunction

    function automatic string record_text(input tspp_pkg::record_t r);
        return {$sformatf("kind %0d pid %h tei %b pusi %b prio %b tsc %0d ",
                          r.record_kind, r.pid_value, r.error_flag, r.unit_start_flag,
                          r.priority_flag, r.scrambling_bits),
                $sformatf("afc %0d cc %0d prog %h type %h info %h",
                          r.adaptation_bits, r.continuity_count, r.program_id,
                          r.stream_kind, r.info_length)};
    endfunction

    // Fills the packet buffer with random bytes and sets the four header bytes.
    task automatic start_packet(input logic [7:0] sync, input logic [2:0] flags,
                                input logic [12:0] pid, input logic [7:0] tail);
        int i;
        for (i = 0; i < tspp_pkg::PACKET_BYTES; i++) begin
            pkt_buf[i] = 8'($urandom_range(0, 255));
        end
        pkt_buf[0] = sync;
        pkt_buf[1] = {flags, pid[12:8]};
        pkt_buf[2] = pid[7:0];
        pkt_buf[3] = tail;
    endtask

    task automatic set_section(input logic [7:0] tid_value, input logic [11:0] sec_len);
        pkt_buf[tspp_pkg::POS_TID]        = tid_value;
        pkt_buf[tspp_pkg::POS_SEC_LEN_HI] = {pkt_buf[tspp_pkg::POS_SEC_LEN_HI][7:4],
                                             sec_len[11:8]};
        pkt_buf[tspp_pkg::POS_SEC_LEN_LO] = sec_len[7:0];
    endtask

    // A negative length override means the section ends right after the last entry.
    task automatic fill_pat(input int n_entries, input bit extremes, input int len_override);
        int          i;
        int          j;
        int          at;
        logic [11:0] sec_len;
        at = int'(tspp_pkg::POS_BODY);
        for (i = 0; i < n_entries && at + 4 <= tspp_pkg::PACKET_BYTES; i++) begin
            if (extremes) begin
                for (j = 0; j < 4; j++) begin
                    pkt_buf[at + j] = (i % 2 == 1) ? 8'h00 : 8'hFF;
                end
            end
            at += 4;
        end
        sec_len = (len_override >= 0) ? 12'(len_override) : 12'(at - 4);
        set_section(tspp_pkg::TID_PAT, sec_len);
    endtask

    task automatic fill_pmt(input logic [15:0] prog, input logic [12:0] pcr,
                            input logic [11:0] info_len, input int n_streams, input int es_cap,
                            input bit extremes, input int len_override);
        int          i;
        int          at;
        logic [7:0]  kind;
        logic [12:0] epid;
        logic [11:0] es_len;
        logic [11:0] sec_len;
        pkt_buf[tspp_pkg::POS_PROG_HI] = prog[15:8];
        pkt_buf[tspp_pkg::POS_PROG_LO] = prog[7:0];
        pkt_buf[13] = {pkt_buf[13][7:5], pcr[12:8]};
        pkt_buf[14] = pcr[7:0];
        pkt_buf[15] = {pkt_buf[15][7:4], info_len[11:8]};
        pkt_buf[16] = info_len[7:0];
        at = int'(tspp_pkg::POS_PMT_HEAD) + 1 + int'(info_len);
        for (i = 0; i < n_streams && at + 5 <= tspp_pkg::PACKET_BYTES; i++) begin
            if (extremes) begin
                kind   = (i % 2 == 1) ? 8'h00 : 8'hFF;
                epid   = (i % 2 == 1) ? 13'h0000 : 13'h1FFF;
                es_len = (i % 2 == 1) ? 12'(es_cap) : 12'd0;
            end else begin
                kind   = 8'($urandom_range(0, 255));
                epid   = 13'($urandom_range(0, 8191));
                es_len = 12'($urandom_range(0, es_cap));
            end
            pkt_buf[at]     = kind;
            pkt_buf[at + 1] = {pkt_buf[at + 1][7:5], epid[12:8]};
            pkt_buf[at + 2] = epid[7:0];
            pkt_buf[at + 3] = {pkt_buf[at + 3][7:4], es_len[11:8]};
            pkt_buf[at + 4] = es_len[7:0];
            at += 5 + int'(es_len);
        end
        if (len_override >= 0) begin
            sec_len = 12'(len_override);
        end else begin
            sec_len = (at - 4 > 4095) ? 12'hFFF : 12'(at - 4);
        end
        set_section(tspp_pkg::TID_PMT, sec_len);
    endtask

    // The stream stops at its planned length, even in the middle of a packet.
    task automatic ship_packet();
        int i;
        for (i = 0; i < tspp_pkg::PACKET_BYTES && bytes_total < STREAM_BYTES; i++) begin
            pending_bytes.push_back(pkt_buf[i]);
            bytes_total++;
        end
    endtask

    // Mostly well-formed PAT and PMT packets, with foreign tables, lost sync and noise.
    task automatic queue_random_packet();
        int          pick;
        int          len_override;
        logic [2:0]  flags;
        logic [7:0]  tail;
        logic [7:0]  sync;
        logic [7:0]  tid;
        logic [11:0] info_len;
        pick  = int'($urandom_range(0, 99));
        flags = 3'($urandom_range(0, 7));
        tail  = 8'($urandom_range(0, 255));
        len_override = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 4095)) : -1;
        if (pick < 35) begin
            start_packet(tspp_pkg::SYNC_MARK, flags, 13'd0, tail);
            fill_pat(int'($urandom_range(0, 43)), 1'b0, len_override);
        end else if (pick < 70) begin
            start_packet(tspp_pkg::SYNC_MARK, flags, 13'($urandom_range(0, 8191)), tail);
            info_len = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 4095))
                                                   : 12'($urandom_range(0, 12));
            fill_pmt(16'($urandom_range(0, 65535)), 13'($urandom_range(0, 8191)), info_len,
                     int'($urandom_range(0, 14)), 12, 1'b0, len_override);
        end else if (pick < 80) begin
            start_packet(tspp_pkg::SYNC_MARK, flags, 13'($urandom_range(1, 8191)), tail);
            tid = 8'($urandom_range(0, 255));
            if (tid == tspp_pkg::TID_PMT) begin
                tid = 8'h01;
            end
            set_section(tid, 12'($urandom_range(0, 4095)));
        end else if (pick < 90) begin
            sync = 8'($urandom_range(0, 254));
            if (sync >= tspp_pkg::SYNC_MARK) begin
                sync = sync + 8'd1;
            end
            start_packet(sync, flags, 13'd0, tail);
            fill_pat(int'($urandom_range(0, 43)), 1'b0, -1);
        end else begin
            sync = ($urandom_range(0, 1) == 1) ? tspp_pkg::SYNC_MARK
                                               : 8'($urandom_range(0, 255));
            start_packet(sync, flags, 13'($urandom_range(0, 8191)), tail);
        end
        ship_packet();
    endtask

    // Byte source: sampling of the handshake at the rising edge feeds the prediction.
    always @(posedge aclk) begin
        byte_taken = aresetn && s_valid && s_ready;
        if (byte_taken) begin
            parse_stream_byte(s_byte_value);
            bytes_taken++;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || byte_taken)) begin
            if (pending_bytes.size() != 0 && (calm_phase || $urandom_range(0, 99) >= 24)) begin
                s_valid      <= 1'b1;
                s_byte_value <= pending_bytes.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Record sink, with one long hold-off so the parser backs up into its input.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_ready      <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end else if (!holdoff_done && bytes_taken >= HOLDOFF_AT) begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= calm_phase || ($urandom_range(0, 99) >= 24);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_rec = {m_record_kind, m_pid_value, m_error_flag, m_unit_start_flag,
                        m_priority_flag, m_scrambling_bits, m_adaptation_bits,
                        m_continuity_count, m_program_id, m_stream_kind, m_info_length};
            records_seen++;
            kind_seen[m_record_kind]++;
            if (expected_records.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("Unexpected record: %s", record_text(seen_rec));
                end
            end else begin
                want_rec = expected_records.pop_front();
                if (seen_rec !== want_rec) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Record mismatch\n  expected %s\n  actual   %s",
                                 record_text(want_rec), record_text(seen_rec));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        // PAT of alternating all-ones and all-zeros entries up to the packet end; the
        // saturated section length keeps every whole entry, and the packet end cuts the partial tail entry.
        start_packet(tspp_pkg::SYNC_MARK, 3'b111, 13'd0, 8'hFF);
        fill_pat(43, 1'b1, 4095);
        ship_packet();
        // PMT on the highest PID with extreme stream entries and skipped descriptors,
        // running past the packet end so the last partial entry is dropped.
        start_packet(tspp_pkg::SYNC_MARK, 3'b000, 13'h1FFF, 8'h00);
        fill_pmt(16'hFFFF, 13'h1FFF, 12'd2, 40, 3, 1'b1, 4095);
        ship_packet();
        // A good PAT body behind a bad sync byte must vanish entirely.
        start_packet(8'h46, 3'b010, 13'd0, 8'h11);
        fill_pat(5, 1'b0, -1);
        ship_packet();
        // Too short a PMT section still gives the map header, with the widest info length.
        start_packet(tspp_pkg::SYNC_MARK, 3'b011, 13'h0000, 8'h96);
        fill_pmt(16'h0000, 13'h0000, 12'hFFF, 0, 0, 1'b0, 0);
        ship_packet();

        while (bytes_total < STREAM_BYTES) begin
            queue_random_packet();
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken != bytes_total || expected_records.size() != 0) begin
            @(negedge aclk);
        end
        repeat (END_PAUSE) @(negedge aclk);

        $display("Streamed %0d bytes: PAT/PMT edge packets, lost sync, random packets, long stall.",
                 bytes_taken);
        $display("Checked %0d records (%0d headers, %0d PAT, %0d PMT heads, %0d streams), %0d errors.",
                 records_seen, kind_seen[tspp_pkg::KIND_HEADER],
                 kind_seen[tspp_pkg::KIND_PAT_ENTRY], kind_seen[tspp_pkg::KIND_PMT_HEAD],
                 kind_seen[tspp_pkg::KIND_PMT_ENTRY], error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
